// ----- src/bhpq_pkg.sv -----
// bhpq_pkg: shared types, codes and the key compare for the heap queue
`timescale 1ns / 1ps
package bhpq_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // status codes on the result channel
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  // configuration register indexes
  localparam logic CFG_HEAP_ORDER = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  localparam int KeyW  = 32;
  localparam int DocW  = 32;
  localparam int CapW  = 11;
  localparam int FillW = 11;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_LD,
    S_UP,
    S_DN,
    S_DONE
  } eng_state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [DocW-1:0] doc;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t ent;
  } cmd_t;

  // true when key a must sit above key b; ties never rank
  function automatic logic ranks_before(input logic order, input logic [KeyW-1:0] a,
                                        input logic [KeyW-1:0] b);
    logic res;
    if (order) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

// ----- src/bhpq_front.sv -----
// bhpq_front: input channel, request decode and two-entry command queue
`timescale 1ns / 1ps
module bhpq_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [31:0]           entry_key_i,
  input  logic [31:0]           entry_doc_i,
  output logic                  cmd_valid_o,
  output bhpq_pkg::cmd_t        cmd_o,
  input  logic                  cmd_take_i
);
  import bhpq_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       push, pop;

  // classify the incoming item
  always_comb begin
    cmd_new.ent.key = entry_key_i;
    cmd_new.ent.doc = entry_doc_i;
    case (req_type_i)
      REQ_PUSH:  cmd_new.op = OP_PUSH;
      REQ_POP:   cmd_new.op = OP_POP;
      REQ_CLEAR: cmd_new.op = OP_CLEAR;
      default:   cmd_new.op = OP_NOP;
    endcase
  end

  // queue handshake
  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_take_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- src/bhpq_engine.sv -----
// bhpq_engine: heap memory, sift sequencer and result register
`timescale 1ns / 1ps
module bhpq_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  heap_order_i,
  input  logic [10:0]           capacity_i,
  input  logic                  cmd_valid_i,
  input  bhpq_pkg::cmd_t        cmd_i,
  output logic                  cmd_take_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [31:0]           top_key_o,
  output logic [31:0]           top_doc_o,
  output logic [10:0]           fill_count_o
);
  import bhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > CapW) ? CW : CapW;

  eng_state_e      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   pos_q, pos_d;
  entry_t          ent_q, ent_d;
  logic [1:0]      res_sts_q, res_sts_d;
  logic [KeyW-1:0] res_key_q, res_key_d;
  logic [DocW-1:0] res_doc_q, res_doc_d;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_sts_q;
  logic [KeyW-1:0] out_key_q;
  logic [DocW-1:0] out_doc_q;
  logic [FillW-1:0] out_fill_q;

  entry_t          heap_mem [0:CAPACITY];
  entry_t          rd_a_q, rd_b_q;
  logic            mem_we;
  logic [CW-1:0]   mem_wa, mem_ra_a, mem_ra_b;
  entry_t          mem_wd;

  logic [LW-1:0]   limit, count_w;
  logic            heap_full;
  logic [CW-1:0]   new_pos;
  logic            up_move;
  logic [CW:0]     lch_w, rch_w, cnt_w;
  logic            l_ok, r_ok, pick_l, pick_r, dn_move;
  logic [CW-1:0]   child;
  logic            out_free, out_load;

  // capacity limit and full test
  always_comb begin
    limit   = (LW'(capacity_i) < LW'(CAPACITY)) ? LW'(capacity_i) : LW'(CAPACITY);
    count_w = LW'(count_q);
    heap_full = (count_w >= limit);
    new_pos = count_q + CW'(1);
  end

  // sift-up compare: moving entry against its parent
  assign up_move = (pos_q != CW'(1)) && ranks_before(heap_order_i, ent_q.key, rd_a_q.key);

  // sift-down compare: moving entry against both children
  always_comb begin
    lch_w  = {pos_q, 1'b0};
    rch_w  = {pos_q, 1'b1};
    cnt_w  = {1'b0, count_q};
    l_ok   = (lch_w <= cnt_w);
    r_ok   = (rch_w <= cnt_w);
    pick_l = l_ok && ranks_before(heap_order_i, rd_a_q.key, ent_q.key);
    pick_r = r_ok && ranks_before(heap_order_i, rd_b_q.key,
                                  pick_l ? rd_a_q.key : ent_q.key);
    dn_move = pick_l || pick_r;
    child   = pick_r ? rch_w[CW-1:0] : lch_w[CW-1:0];
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUSH: state_d = heap_full ? S_DONE : S_UP;
            OP_POP:  state_d = (count_q == '0) ? S_DONE : S_POP_LD;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_POP_LD: state_d = (count_q == '0) ? S_DONE : S_DN;
      S_UP:     state_d = up_move ? S_UP : S_DONE;
      S_DN:     state_d = dn_move ? S_DN : S_DONE;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    ent_d     = ent_q;
    res_sts_d = res_sts_q;
    res_key_d = res_key_q;
    res_doc_d = res_doc_q;
    mem_we    = 1'b0;
    mem_wa    = pos_q;
    mem_wd    = ent_q;
    mem_ra_a  = '0;
    mem_ra_b  = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          res_sts_d = STS_OK;
          res_key_d = '0;
          res_doc_d = '0;
          case (cmd_i.op)
            OP_PUSH: begin
              if (heap_full) begin
                res_sts_d = STS_FULL;
              end else begin
                count_d  = new_pos;
                pos_d    = new_pos;
                ent_d    = cmd_i.ent;
                mem_ra_a = new_pos >> 1;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_sts_d = STS_EMPTY;
              end else begin
                count_d  = count_q - CW'(1);
                mem_ra_a = CW'(1);
                mem_ra_b = count_q;
              end
            end
            OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_POP_LD: begin
        // top goes out, last entry restarts at the root
        res_key_d = rd_a_q.key;
        res_doc_d = rd_a_q.doc;
        ent_d     = rd_b_q;
        pos_d     = CW'(1);
        mem_ra_a  = CW'(2);
        mem_ra_b  = CW'(3);
      end
      S_UP: begin
        mem_we = 1'b1;
        if (up_move) begin
          mem_wd   = rd_a_q;
          pos_d    = pos_q >> 1;
          mem_ra_a = pos_q >> 2;
        end
      end
      S_DN: begin
        mem_we = 1'b1;
        if (dn_move) begin
          mem_wd   = pick_r ? rd_b_q : rd_a_q;
          pos_d    = child;
          mem_ra_a = {child[CW-2:0], 1'b0};
          mem_ra_b = {child[CW-2:0], 1'b1};
        end
      end
      default: ;
    endcase
  end

  // result register next valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    ent_q     <= ent_d;
    res_sts_q <= res_sts_d;
    res_key_q <= res_key_d;
    res_doc_q <= res_doc_d;
    if (out_load) begin
      out_sts_q  <= res_sts_q;
      out_key_q  <= res_key_q;
      out_doc_q  <= res_doc_q;
      out_fill_q <= count_w[FillW-1:0];
    end
  end

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= heap_mem[mem_ra_a];
    rd_b_q <= heap_mem[mem_ra_b];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_sts_q;
  assign top_key_o    = out_key_q;
  assign top_doc_o    = out_doc_q;
  assign fill_count_o = out_fill_q;

endmodule

// ----- src/binary_heap_priority_queue.sv -----
// binary_heap_priority_queue: top level with config registers and checks
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------------------
//   in       | input     | in_valid_i/in_stall_o | req_type_i, entry_key_i, entry_doc_i
//   out      | output    | out_valid_o/out_stall_i | status_o, top_key_o, top_doc_o,
//            |           |                       | fill_count_o
//   cfg      | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// push passes IDLE, UP and DONE, pop IDLE, POP_LD, DN and DONE; UP and DN repeat
// while the entry moves, at most log2(CAPACITY) levels (10 at the default), one level a
// cycle on the two-read heap ram; a pop that takes the last entry skips DN
// clear, rejected and empty requests skip to DONE; a two-entry queue takes items meanwhile
// reset empties the heap, sets smallest-first order and capacity 1024; no clearing pass
// a stalled result waits in the output register while the next item is already in work
`timescale 1ns / 1ps
module binary_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] entry_key_i,
  input  logic [31:0] entry_doc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] top_key_o,
  output logic [31:0] top_doc_o,
  output logic [10:0] fill_count_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import bhpq_pkg::*;

  logic        heap_order_q;
  logic [10:0] capacity_q;
  logic        cmd_valid, cmd_take;
  cmd_t        cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_order_q <= 1'b0;
      capacity_q   <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAP_ORDER: heap_order_q <= cfg_data_i[0];
        CFG_CAPACITY:   capacity_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bhpq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .entry_key_i (entry_key_i),
    .entry_doc_i (entry_doc_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  bhpq_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_order_i (heap_order_q),
    .capacity_i   (capacity_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_take_o   (cmd_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .top_key_o    (top_key_o),
    .top_doc_o    (top_doc_o),
    .fill_count_o (fill_count_o)
  );

  // only a successful pop carries an entry
  a_top_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STS_OK) |-> (top_key_o == '0) && (top_doc_o == '0))
    else $error("rejected request reports a nonzero entry");

  // an empty report leaves the fill at zero
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_EMPTY) |-> (fill_count_o == '0))
    else $error("empty status with nonzero fill");

  // status is always one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STS_OK) || (status_o == STS_EMPTY) ||
                    (status_o == STS_FULL))
    else $error("undefined status code");

endmodule
